FILE: rtl/lgsc_pkg.sv
// Shared types and constants for the glyph slot cache.
`timescale 1ns / 1ps
package lgsc_pkg;

    localparam int KEY_W      = 29;
    localparam int VARIANT_W  = 8;
    localparam int CODEPT_W   = 21;
    localparam int CAP_W      = 7;
    localparam int BYTES_W    = 13;
    localparam int STATUS_W   = 3;
    localparam int IDX_OUT_W  = 6;
    localparam int OFF_W      = 18;
    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 1;

    localparam logic [BYTES_W-1:0] MAX_SLOT_BYTES = 13'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CACHE_CAP  = 1'b0,
        CFG_SLOT_BYTES = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_LOOKUP   = 2'd0,
        OP_ALLOCATE = 2'd1,
        OP_ABORT    = 2'd2,
        OP_CLEAR    = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_DISABLED = 3'd2,
        ST_EVICTED  = 3'd3,
        ST_NO_SLOT  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_CLEAR,
        CMD_SCAN_NEXT,
        CMD_FOUND,
        CMD_UNLINK,
        CMD_FREE_PUSH,
        CMD_TAKE_FRESH,
        CMD_TAKE_RD,
        CMD_TAKE_POP,
        CMD_EVICT,
        CMD_PUSH_LINK,
        CMD_PUSH_HEAD,
        CMD_RESULT
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_HIT,
        S_ALLOC,
        S_LINK_RD,
        S_UNLINK,
        S_FREE_PUSH,
        S_TAKE_POP,
        S_PUSH_LINK,
        S_PUSH_HEAD,
        S_RESULT
    } t_state;

    typedef struct packed {
        t_cmd    cmd;
        t_status status;
        logic    use_slot;
    } t_ctl;

    typedef struct packed {
        logic hit;
        logic last;
        logic head_is_slot;
        logic free_nil;
        logic free_fresh;
        logic tail_nil;
        logic disabled;
        logic out_busy;
    } t_sts;

endpackage

FILE: rtl/lru_glyph_slot_cache.sv
// Top level of the least-recently-used glyph slot cache.
`timescale 1ns / 1ps
//
//  Channel   Direction  Beat contents
//  s_*       in         tdata: variant, codepoint; tuser: opcode
//  m_*       out        tdata: status, slot_index, slot_offset
//  i_cfg_*   in         register index and write data, one write per enabled cycle
//
//  The key search does one read and one compare per slot, up to the live capacity, set by
//  the single read port of the key memory; it is followed by list relinking and result
//  hand-off. A clear, or a lookup or allocate while the cache is disabled, skips the search
//  and goes straight to the result.
//  Reset is synchronous and active low; it needs no clearing pass, since untaken slots
//  are tracked by a fill count. A stalled result sits in the output register while the
//  next beat is taken; its result waits until the register is free.
module lru_glyph_slot_cache #(
    parameter int SLOTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // [7:0] variant, [28:8] codepoint, rest zero
    input  logic [1:0]  s_tuser,  // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // [2:0] status, [8:3] slot_index, [26:9] slot_offset
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_wdata
);
    import lgsc_pkg::*;

    t_ctl ctl;
    t_sts sts;

    // The controller sequences each beat; the datapath holds all storage.
    lgsc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_tvalid),
        .o_ready  (s_tready),
        .i_opcode (s_tuser),
        .i_sts    (sts),
        .o_ctl    (ctl)
    );

    // The key is the variant above the codepoint.
    lgsc_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_key       ({s_tdata[VARIANT_W-1:0], s_tdata[VARIANT_W+CODEPT_W-1:VARIANT_W]}),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (m_tvalid),
        .i_ready     (m_tready),
        .o_data      (m_tdata)
    );

endmodule

FILE: rtl/lgsc_datapath.sv
// Datapath of the glyph slot cache: key and link memories, list pointers, result register.
`timescale 1ns / 1ps
module lgsc_datapath #(
    parameter int SLOTS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lgsc_pkg::t_ctl                i_ctl,
    output lgsc_pkg::t_sts                o_sts,
    input  logic [lgsc_pkg::KEY_W-1:0]    i_key,
    input  logic                          i_cfg_we,
    input  logic [lgsc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lgsc_pkg::BYTES_W-1:0]  i_cfg_wdata,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [lgsc_pkg::DATA_W-1:0]   o_data
);
    import lgsc_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW = $clog2(SLOTS + 1);
    localparam logic [LW-1:0] NIL = LW'(SLOTS);
    localparam logic [LW-1:0] RST_CAP = (SLOTS < 64) ? LW'(SLOTS) : LW'(64);

    logic [KEY_W-1:0]   r_key_mem  [SLOTS];
    logic [LW-1:0]      r_prev_mem [SLOTS];
    logic [LW-1:0]      r_next_mem [SLOTS];
    logic [SLOTS-1:0]   r_used;

    logic [KEY_W-1:0]   r_key;
    logic [KEY_W-1:0]   r_key_rd;
    logic [LW-1:0]      r_prev_rd;
    logic [LW-1:0]      r_next_rd;
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      r_slot;
    logic [LW-1:0]      r_free_head;
    logic [LW-1:0]      r_fresh;
    logic [LW-1:0]      r_head;
    logic [LW-1:0]      r_tail;
    logic [LW-1:0]      r_live_cap;
    logic [CAP_W-1:0]   r_cfg_cap;
    logic [BYTES_W-1:0] r_cfg_bytes;
    logic               r_valid;
    logic [DATA_W-1:0]  r_data;

    logic [LW-1:0]      cap_eff;
    logic [LW-1:0]      idx_inc;
    logic [LW-1:0]      free_inc;
    logic [IW-1:0]      next_rd_addr;
    logic               next_we;
    logic [IW-1:0]      next_wa;
    logic [LW-1:0]      next_wd;
    logic               prev_we;
    logic [IW-1:0]      prev_wa;
    logic [LW-1:0]      prev_wd;
    logic [BYTES_W-1:0] bytes_eff;
    logic [31:0]        offset_full;
    logic [IDX_OUT_W-1:0] slot_out;
    logic [OFF_W-1:0]   off_out;

    always_comb begin
        if (r_cfg_cap == '0) begin
            cap_eff = LW'(1);
        end else if (32'(r_cfg_cap) > SLOTS) begin
            cap_eff = NIL;
        end else begin
            cap_eff = LW'(r_cfg_cap);
        end
    end

    assign idx_inc  = LW'(r_idx) + LW'(1);
    assign free_inc = r_free_head + LW'(1);
    assign next_rd_addr = (i_ctl.cmd == CMD_TAKE_RD) ? r_free_head[IW-1:0] : r_slot;

    // Write ports of the two link memories.
    always_comb begin
        next_we = 1'b0;
        next_wa = r_slot;
        next_wd = NIL;
        prev_we = 1'b0;
        prev_wa = r_slot;
        prev_wd = NIL;
        case (i_ctl.cmd)
            CMD_UNLINK: begin
                next_we = (r_prev_rd != NIL);
                next_wa = r_prev_rd[IW-1:0];
                next_wd = r_next_rd;
                prev_we = (r_next_rd != NIL);
                prev_wa = r_next_rd[IW-1:0];
                prev_wd = r_prev_rd;
            end
            CMD_FREE_PUSH: begin
                next_we = 1'b1;
                next_wd = r_free_head;
                prev_we = 1'b1;
            end
            CMD_PUSH_LINK: begin
                next_we = 1'b1;
                next_wd = r_head;
                prev_we = (r_head != NIL);
                prev_wa = r_head[IW-1:0];
                prev_wd = LW'(r_slot);
            end
            CMD_PUSH_HEAD: begin
                prev_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key_rd  <= r_key_mem[r_idx];
        r_prev_rd <= r_prev_mem[r_slot];
        r_next_rd <= r_next_mem[next_rd_addr];
        if (next_we) begin
            r_next_mem[next_wa] <= next_wd;
        end
        if (prev_we) begin
            r_prev_mem[prev_wa] <= prev_wd;
        end
        if (i_ctl.cmd == CMD_PUSH_HEAD) begin
            r_key_mem[r_slot] <= r_key;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            CMD_ACCEPT: begin
                r_key <= i_key;
                r_idx <= '0;
            end
            CMD_SCAN_NEXT: r_idx  <= r_idx + IW'(1);
            CMD_FOUND:     r_slot <= r_idx;
            CMD_TAKE_FRESH, CMD_TAKE_RD: r_slot <= r_free_head[IW-1:0];
            CMD_EVICT:     r_slot <= r_tail[IW-1:0];
            CMD_RESULT:    r_data <= {{(DATA_W - STATUS_W - IDX_OUT_W - OFF_W){1'b0}},
                                      off_out, slot_out, i_ctl.status};
            default: begin
            end
        endcase
    end

    assign bytes_eff   = (r_cfg_bytes > MAX_SLOT_BYTES) ? MAX_SLOT_BYTES : r_cfg_bytes;
    assign offset_full = 32'(r_slot) * 32'(bytes_eff);
    assign slot_out    = i_ctl.use_slot ? IDX_OUT_W'(32'(r_slot)) : '0;
    assign off_out     = i_ctl.use_slot ? offset_full[OFF_W-1:0] : '0;

    // Control state: list pointers, occupancy, configuration, result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_free_head <= '0;
            r_fresh     <= '0;
            r_head      <= NIL;
            r_tail      <= NIL;
            r_live_cap  <= RST_CAP;
            r_cfg_cap   <= CAP_W'(64);
            r_cfg_bytes <= '0;
            r_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CACHE_CAP:  r_cfg_cap   <= i_cfg_wdata[CAP_W-1:0];
                    CFG_SLOT_BYTES: r_cfg_bytes <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            case (i_ctl.cmd)
                CMD_CLEAR: begin
                    r_used      <= '0;
                    r_free_head <= '0;
                    r_fresh     <= '0;
                    r_head      <= NIL;
                    r_tail      <= NIL;
                    r_live_cap  <= cap_eff;
                end
                CMD_UNLINK: begin
                    if (r_prev_rd == NIL) begin
                        r_head <= r_next_rd;
                    end
                    if (r_next_rd == NIL) begin
                        r_tail <= r_prev_rd;
                    end
                end
                CMD_FREE_PUSH: begin
                    r_used[r_slot] <= 1'b0;
                    r_free_head    <= LW'(r_slot);
                end
                CMD_TAKE_FRESH: begin
                    // Slots not yet handed out form an implicit ascending chain.
                    r_free_head <= (free_inc < r_live_cap) ? free_inc : NIL;
                    r_fresh     <= r_fresh + LW'(1);
                end
                CMD_TAKE_POP: r_free_head <= r_next_rd;
                CMD_EVICT:    r_used[r_tail[IW-1:0]] <= 1'b0;
                CMD_PUSH_HEAD: begin
                    r_used[r_slot] <= 1'b1;
                    r_head         <= LW'(r_slot);
                    if (r_tail == NIL) begin
                        r_tail <= LW'(r_slot);
                    end
                end
                CMD_RESULT: r_valid <= 1'b1;
                default: begin
                end
            endcase
        end
    end

    assign o_sts.hit          = r_used[r_idx] && (r_key_rd == r_key);
    assign o_sts.last         = (idx_inc >= r_live_cap);
    assign o_sts.head_is_slot = (r_head == LW'(r_slot));
    assign o_sts.free_nil     = (r_free_head == NIL);
    assign o_sts.free_fresh   = (r_free_head == r_fresh);
    assign o_sts.tail_nil     = (r_tail == NIL);
    assign o_sts.disabled     = (r_cfg_bytes == '0);
    assign o_sts.out_busy     = r_valid && !i_ready;

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/lgsc_ctrl.sv
// Sequencer of the glyph slot cache: steps each request through the scan and relink states it needs, then the result.
`timescale 1ns / 1ps
module lgsc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [1:0]     i_opcode,
    input  lgsc_pkg::t_sts i_sts,
    output lgsc_pkg::t_ctl o_ctl
);
    import lgsc_pkg::*;

    t_state  r_state,  n_state;
    t_op     r_op,     n_op;
    t_status r_status, n_status;
    logic    r_use,    n_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_LOOKUP;
            r_status <= ST_HIT;
            r_use    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_status <= n_status;
            r_use    <= n_use;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_status = r_status;
        n_use    = r_use;
        o_ready  = 1'b0;
        o_ctl.cmd      = CMD_NONE;
        o_ctl.status   = r_status;
        o_ctl.use_slot = r_use;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_op     = t_op'(i_opcode);
                    n_status = ST_HIT;
                    n_use    = 1'b0;
                    if (t_op'(i_opcode) == OP_CLEAR) begin
                        o_ctl.cmd = CMD_CLEAR;
                        n_state   = S_RESULT;
                    end else if (t_op'(i_opcode) != OP_ABORT && i_sts.disabled) begin
                        n_status = ST_DISABLED;
                        n_state  = S_RESULT;
                    end else begin
                        o_ctl.cmd = CMD_ACCEPT;
                        n_state   = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: n_state = S_SCAN_CMP;
            S_SCAN_CMP: begin
                if (i_sts.hit) begin
                    o_ctl.cmd = CMD_FOUND;
                    n_status  = ST_HIT;
                    n_use     = 1'b1;
                    n_state   = S_HIT;
                end else if (!i_sts.last) begin
                    o_ctl.cmd = CMD_SCAN_NEXT;
                    n_state   = S_SCAN_RD;
                end else if (r_op == OP_ALLOCATE) begin
                    n_state = S_ALLOC;
                end else begin
                    n_status = ST_MISS;
                    n_state  = S_RESULT;
                end
            end
            S_HIT: begin
                if (r_op != OP_ABORT && i_sts.head_is_slot) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_LINK_RD;
                end
            end
            S_ALLOC: begin
                if (!i_sts.free_nil) begin
                    n_use = 1'b1;
                    if (i_sts.free_fresh) begin
                        o_ctl.cmd = CMD_TAKE_FRESH;
                        n_state   = S_PUSH_LINK;
                    end else begin
                        o_ctl.cmd = CMD_TAKE_RD;
                        n_state   = S_TAKE_POP;
                    end
                end else if (!i_sts.tail_nil) begin
                    o_ctl.cmd = CMD_EVICT;
                    n_status  = ST_EVICTED;
                    n_use     = 1'b1;
                    n_state   = S_LINK_RD;
                end else begin
                    n_status = ST_NO_SLOT;
                    n_state  = S_RESULT;
                end
            end
            S_LINK_RD: n_state = S_UNLINK;
            S_UNLINK: begin
                o_ctl.cmd = CMD_UNLINK;
                n_state   = (r_op == OP_ABORT) ? S_FREE_PUSH : S_PUSH_LINK;
            end
            S_FREE_PUSH: begin
                o_ctl.cmd = CMD_FREE_PUSH;
                n_state   = S_RESULT;
            end
            S_TAKE_POP: begin
                o_ctl.cmd = CMD_TAKE_POP;
                n_state   = S_PUSH_LINK;
            end
            S_PUSH_LINK: begin
                o_ctl.cmd = CMD_PUSH_LINK;
                n_state   = S_PUSH_HEAD;
            end
            S_PUSH_HEAD: begin
                o_ctl.cmd = CMD_PUSH_HEAD;
                n_state   = S_RESULT;
            end
            S_RESULT: begin
                if (!i_sts.out_busy) begin
                    o_ctl.cmd = CMD_RESULT;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
